>>> sv/sba_pkg.sv
// Shared types, constants and codes for the superblock block allocator.
// Depends on nothing; every other file of the block but sba_ram imports it.

package sba_pkg;

   // Superblock geometry and stack size.
   localparam int SUPER_BYTES  = 8192;
   localparam int HEADER_BYTES = 64;
   localparam int MIN_BLOCK    = 8;
   localparam int STACK_DEPTH  = 1024;

   // Field widths.
   localparam int OP_W     = 2;
   localparam int OFS_W    = 13;
   localparam int CNT_W    = 11;
   localparam int USED_W   = 14;
   localparam int PROD_W   = CNT_W + OFS_W;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   localparam int CNT_MAX  = (1 << CNT_W) - 1;
   localparam int USED_MAX = (1 << USED_W) - 1;

   // Free stack addressing; the depth counter holds the full depth as well.
   localparam int STK_AW = $clog2(STACK_DEPTH);
   localparam int DEP_W  = STK_AW + 1;

   // Bytes that blocks may occupy and the divider that splits them up.
   localparam int NUM_BYTES = (SUPER_BYTES > HEADER_BYTES) ? SUPER_BYTES - HEADER_BYTES : 0;
   localparam int NUM_W     = (NUM_BYTES > 0) ? $clog2(NUM_BYTES + 1) : 1;
   localparam int DIV_CW    = (NUM_W > 1) ? $clog2(NUM_W) : 1;

   // State after reset.
   localparam int RESET_SIZE  = 64;
   localparam int RESET_QUO   = NUM_BYTES / RESET_SIZE;
   localparam int RESET_TOTAL = (RESET_QUO > CNT_MAX) ? CNT_MAX : RESET_QUO;
   localparam logic [OFS_W-1:0] HEADER_OFS = OFS_W'(HEADER_BYTES);

   // Queue between front and back, and the result queue (power-of-two depth).
   localparam int Q_DEPTH = 2;
   localparam int Q_AW    = $clog2(Q_DEPTH);
   localparam int Q_CW    = Q_AW + 1;

   // Configuration register index.
   localparam logic REG_BLK_BYTES = 1'b0;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC   = 2'd0,
      OP_RELEASE = 2'd1,
      OP_REINIT  = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_NO_BLOCK    = 2'd1,
      ST_MISALIGNED  = 2'd2,
      ST_STACK_FULL  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CLS_NOP        = 3'd0,
      CLS_ALLOC      = 3'd1,
      CLS_RELEASE    = 3'd2,
      CLS_MISALIGNED = 3'd3,
      CLS_REINIT     = 3'd4
   } cls_type;

   typedef struct packed {
      cls_type            cls;
      logic [OFS_W-1:0]   offset;
   } work_type;

   typedef struct packed {
      logic [OFS_W-1:0]   block_offset;
      status_type         status;
      logic               from_reap;
      logic [CNT_W-1:0]   free_count;
      logic               all_free;
      logic [USED_W-1:0]  bytes_used;
   } rsp_type;

endpackage

>>> sv/sba_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.

module sba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/sba_front.sv
// Front end: accepts request transactions, classifies them and queues them.
// Depends on sba_pkg.

module sba_front import sba_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [OP_W-1:0]   operation,
   input  logic [OFS_W-1:0]  offset,
   output logic              wq_empty,
   output work_type          wq_head,
   input  logic              wq_pop
);

   cls_type           cls;
   logic              misaligned;
   logic              do_push;
   logic              do_pop;
   work_type          entry_ff [Q_DEPTH];
   logic [Q_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CW-1:0]   count_ff, count_in;

   // A release offset must sit on a minimum block boundary.
   assign misaligned = (OFS_W'(offset % OFS_W'(MIN_BLOCK)) != '0);

   // Classify the operation so the back end needs no offset arithmetic.
   always_comb begin
      cls = CLS_NOP;
      unique case (op_type'(operation))
         OP_ALLOC:   cls = CLS_ALLOC;
         OP_RELEASE: cls = misaligned ? CLS_MISALIGNED : CLS_RELEASE;
         OP_REINIT:  cls = CLS_REINIT;
         OP_NONE:    cls = CLS_NOP;
         default:    cls = CLS_NOP;
      endcase
   end

   // Queue handshake and pointer updates.
   assign full     = (count_ff == Q_CW'(Q_DEPTH));
   assign wq_empty = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = wq_pop && !wq_empty;
   assign wr_ptr_in = do_push ? Q_AW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? Q_AW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
   assign count_in  = Q_CW'(count_ff + Q_CW'(do_push) - Q_CW'(do_pop));
   assign wq_head   = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= '{cls: cls, offset: offset};
      end
   end

endmodule

>>> sv/sba_div.sv
// Restoring divider that derives the block count from the block size.
// Depends on sba_pkg; one quotient bit per cycle.

module sba_div import sba_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [OFS_W-1:0]  divisor,
   output logic              done,
   output logic [CNT_W-1:0]  total
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic               zero_ff, zero_in;
   logic [DIV_CW-1:0]  cnt_ff, cnt_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [NUM_W-1:0]   quo_ff, quo_in;
   logic [OFS_W-1:0]   rem_ff, rem_in;
   logic [OFS_W-1:0]   dsr_ff, dsr_in;
   logic [OFS_W:0]     rem_sh;
   logic               take;

   // One restoring step: shift in the next dividend bit and try a subtract.
   assign rem_sh = {rem_ff, num_ff[NUM_W-1]};
   assign take   = (rem_sh >= {1'b0, dsr_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      zero_in = zero_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         zero_in = (divisor == '0);
         cnt_in  = '0;
         num_in  = NUM_W'(NUM_BYTES);
         quo_in  = '0;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         num_in = num_ff << 1;
         quo_in = (quo_ff << 1) | NUM_W'(take);
         rem_in = take ? OFS_W'(rem_sh - {1'b0, dsr_ff}) : OFS_W'(rem_sh);
         cnt_in = DIV_CW'(cnt_ff + 1'b1);
         if (cnt_ff == DIV_CW'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      zero_ff <= zero_in;
      cnt_ff  <= cnt_in;
      num_ff  <= num_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   // A zero block size gives no blocks; large counts saturate.
   assign done  = done_ff;
   assign total = zero_ff ? '0 :
                  (32'(quo_ff) > 32'(CNT_MAX)) ? CNT_W'(CNT_MAX) : CNT_W'(quo_ff);

endmodule

>>> sv/sba_back.sv
// Back end: allocator state, free stack, reinitialize sequencing and result queue.
// Depends on sba_pkg, sba_ram and sba_div.

module sba_back import sba_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [OFS_W-1:0]  blk_bytes,
   input  logic              wq_empty,
   input  work_type          wq_head,
   output logic              wq_pop,
   input  logic              rsp_pop,
   output logic              rsp_empty,
   output rsp_type           rsp_head
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_DIV,
      S_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [OFS_W-1:0]   bump_off_ff, bump_off_in;
   logic [CNT_W-1:0]   bump_rem_ff, bump_rem_in;
   logic [CNT_W-1:0]   free_ff, free_in;
   logic [CNT_W-1:0]   total_ff, total_in;
   logic [OFS_W-1:0]   active_ff, active_in;
   logic [DEP_W-1:0]   depth_ff, depth_in;
   logic [OFS_W-1:0]   blk_ff, blk_in;
   status_type         status_ff, status_in;
   logic               reap_ff, reap_in;

   logic [DEP_W-1:0]   depth_dec;
   logic               stack_full;
   logic [CNT_W-1:0]   free_dec;
   logic [CNT_W-1:0]   free_inc;
   logic               ram_we;
   logic               ram_re;
   logic [OFS_W-1:0]   ram_rdata;
   logic               div_start;
   logic               div_done;
   logic [CNT_W-1:0]   div_total;

   logic [CNT_W-1:0]   used_diff;
   logic [PROD_W-1:0]  used_prod;
   logic [USED_W-1:0]  used_sat;
   rsp_type            rsp_new;
   logic               rsp_push;

   rsp_type            oq_ff [Q_DEPTH];
   logic [Q_AW-1:0]    oq_wr_ff, oq_wr_in;
   logic [Q_AW-1:0]    oq_rd_ff, oq_rd_in;
   logic [Q_CW-1:0]    oq_cnt_ff, oq_cnt_in;
   logic               oq_full;
   logic               oq_pop;

   // Free stack storage.
   sba_ram #(
      .WIDTH (OFS_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (depth_ff[STK_AW-1:0]),
      .wr_data (wq_head.offset),
      .rd_en   (ram_re),
      .rd_addr (depth_dec[STK_AW-1:0]),
      .rd_data (ram_rdata)
   );

   // Block count divider for reinitialize.
   sba_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .divisor (blk_bytes),
      .done    (div_done),
      .total   (div_total)
   );

   // Counter helpers.
   assign depth_dec  = DEP_W'(depth_ff - 1'b1);
   assign stack_full = (depth_ff >= DEP_W'(STACK_DEPTH));
   assign free_dec   = (free_ff != '0) ? CNT_W'(free_ff - 1'b1) : free_ff;
   assign free_inc   = (free_ff != CNT_W'(CNT_MAX)) ? CNT_W'(free_ff + 1'b1) : free_ff;

   // Sequencer: execute one queued transaction, then post its result.
   always_comb begin
      state_in    = state_ff;
      bump_off_in = bump_off_ff;
      bump_rem_in = bump_rem_ff;
      free_in     = free_ff;
      total_in    = total_ff;
      active_in   = active_ff;
      depth_in    = depth_ff;
      blk_in      = blk_ff;
      status_in   = status_ff;
      reap_in     = reap_ff;
      wq_pop      = 1'b0;
      ram_we      = 1'b0;
      ram_re      = 1'b0;
      div_start   = 1'b0;
      rsp_push    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (!wq_empty) begin
               wq_pop    = 1'b1;
               blk_in    = '0;
               status_in = ST_OK;
               reap_in   = 1'b0;
               state_in  = S_DONE;
               unique case (wq_head.cls)
                  CLS_ALLOC: begin
                     if (bump_rem_ff != '0) begin
                        blk_in      = bump_off_ff;
                        bump_off_in = OFS_W'(bump_off_ff + active_ff);
                        bump_rem_in = CNT_W'(bump_rem_ff - 1'b1);
                        reap_in     = 1'b1;
                        free_in     = free_dec;
                     end else if (depth_ff != '0) begin
                        depth_in = depth_dec;
                        ram_re   = 1'b1;
                        free_in  = free_dec;
                        state_in = S_READ;
                     end else begin
                        status_in = ST_NO_BLOCK;
                     end
                  end
                  CLS_RELEASE: begin
                     if (stack_full) begin
                        status_in = ST_STACK_FULL;
                     end else begin
                        ram_we   = 1'b1;
                        depth_in = DEP_W'(depth_ff + 1'b1);
                        free_in  = free_inc;
                     end
                  end
                  CLS_MISALIGNED: status_in = ST_MISALIGNED;
                  CLS_REINIT: begin
                     active_in = blk_bytes;
                     div_start = 1'b1;
                     state_in  = S_DIV;
                  end
                  default: ;
               endcase
            end
         end
         S_READ: begin
            blk_in   = ram_rdata;
            state_in = S_DONE;
         end
         S_DIV: begin
            if (div_done) begin
               total_in    = div_total;
               bump_rem_in = div_total;
               free_in     = div_total;
               bump_off_in = HEADER_OFS;
               depth_in    = '0;
               state_in    = S_DONE;
            end
         end
         S_DONE: begin
            if (!oq_full) begin
               rsp_push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         bump_off_ff <= HEADER_OFS;
         bump_rem_ff <= CNT_W'(RESET_TOTAL);
         free_ff     <= CNT_W'(RESET_TOTAL);
         total_ff    <= CNT_W'(RESET_TOTAL);
         active_ff   <= OFS_W'(RESET_SIZE);
         depth_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         bump_off_ff <= bump_off_in;
         bump_rem_ff <= bump_rem_in;
         free_ff     <= free_in;
         total_ff    <= total_in;
         active_ff   <= active_in;
         depth_ff    <= depth_in;
      end
      blk_ff    <= blk_in;
      status_ff <= status_in;
      reap_ff   <= reap_in;
   end

   // Used bytes from the settled counters; zero when more is free than exists.
   assign used_diff = CNT_W'(total_ff - free_ff);
   assign used_prod = PROD_W'(used_diff) * PROD_W'(active_ff);
   assign used_sat  = (total_ff <= free_ff) ? '0 :
                      (used_prod > PROD_W'(USED_MAX)) ? USED_W'(USED_MAX) :
                      USED_W'(used_prod);

   assign rsp_new = '{
      block_offset: blk_ff,
      status:       status_ff,
      from_reap:    reap_ff,
      free_count:   free_ff,
      all_free:     (free_ff == total_ff),
      bytes_used:   used_sat
   };

   // Result queue so a waiting result does not hold up the next transaction.
   assign oq_full   = (oq_cnt_ff == Q_CW'(Q_DEPTH));
   assign rsp_empty = (oq_cnt_ff == '0);
   assign oq_pop    = rsp_pop && !rsp_empty;
   assign oq_wr_in  = rsp_push ? Q_AW'(oq_wr_ff + 1'b1) : oq_wr_ff;
   assign oq_rd_in  = oq_pop ? Q_AW'(oq_rd_ff + 1'b1) : oq_rd_ff;
   assign oq_cnt_in = Q_CW'(oq_cnt_ff + Q_CW'(rsp_push) - Q_CW'(oq_pop));
   assign rsp_head  = oq_ff[oq_rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wr_ff  <= '0;
         oq_rd_ff  <= '0;
         oq_cnt_ff <= '0;
      end else begin
         oq_wr_ff  <= oq_wr_in;
         oq_rd_ff  <= oq_rd_in;
         oq_cnt_ff <= oq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_push) begin
         oq_ff[oq_wr_ff] <= rsp_new;
      end
   end

endmodule

>>> sv/superblock_block_allocator.sv
// Top level of the superblock block allocator: register port and the two halves.
// Depends on sba_pkg, sba_front, sba_back (and through it sba_ram, sba_div).
//
//   Channel    Handshake                          Payload
//   request    push / full                        req_operation, req_offset
//   response   empty / pop                        rsp_block_offset .. rsp_bytes_used
//   registers  psel, penable, pwrite, pready      paddr, pwdata, prdata
//
// Release, misaligned release, bump allocate and unused codes go from S_IDLE straight to S_DONE.
// Allocate from the free stack passes through S_READ on the way, for the stack RAM read.
// Reinitialize waits in S_DIV for the 13-step restoring divider.
// Reset is synchronous; the stack RAM needs no clearing pass.
// Two-entry queues on both sides let input and output stall independently.

module superblock_block_allocator import sba_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   // Request channel.
   input  logic               push,
   output logic               full,
   input  logic [OP_W-1:0]    req_operation,
   input  logic [OFS_W-1:0]   req_offset,
   // Response channel.
   output logic               empty,
   input  logic               pop,
   output logic [OFS_W-1:0]   rsp_block_offset,
   output logic [1:0]         rsp_status,
   output logic               rsp_from_reap,
   output logic [CNT_W-1:0]   rsp_free_count,
   output logic               rsp_all_free,
   output logic [USED_W-1:0]  rsp_bytes_used,
   // Register port.
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [CSR_AW-1:0]  paddr,
   input  logic [CSR_DW-1:0]  pwdata,
   output logic [CSR_DW-1:0]  prdata,
   output logic               pready
);

   logic [OFS_W-1:0]  blk_bytes_ff, blk_bytes_in;
   logic              csr_wr;
   logic              csr_hit;
   logic              wq_empty;
   logic              wq_pop;
   work_type          wq_head;
   rsp_type           rsp_head;

   // Block size register; taken by the next reinitialize transaction.
   assign pready  = 1'b1;
   assign csr_hit = (paddr[2] == REG_BLK_BYTES);
   assign csr_wr  = psel && penable && pwrite && pready && csr_hit;
   assign blk_bytes_in = csr_wr ? pwdata[OFS_W-1:0] : blk_bytes_ff;
   assign prdata  = csr_hit ? CSR_DW'(blk_bytes_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         blk_bytes_ff <= OFS_W'(RESET_SIZE);
      end else begin
         blk_bytes_ff <= blk_bytes_in;
      end
   end

   sba_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .operation (req_operation),
      .offset    (req_offset),
      .wq_empty  (wq_empty),
      .wq_head   (wq_head),
      .wq_pop    (wq_pop)
   );

   sba_back u_back (
      .clock      (clock),
      .reset      (reset),
      .blk_bytes  (blk_bytes_ff),
      .wq_empty   (wq_empty),
      .wq_head    (wq_head),
      .wq_pop     (wq_pop),
      .rsp_pop    (pop),
      .rsp_empty  (empty),
      .rsp_head   (rsp_head)
   );

   assign rsp_block_offset = rsp_head.block_offset;
   assign rsp_status       = rsp_head.status;
   assign rsp_from_reap    = rsp_head.from_reap;
   assign rsp_free_count   = rsp_head.free_count;
   assign rsp_all_free     = rsp_head.all_free;
   assign rsp_bytes_used   = rsp_head.bytes_used;

   // Both queues come out of reset empty.
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (!full && empty))
      else $error("queues not empty after reset");

   // With everything free nothing can count as used.
   a_free_unused: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_all_free) |-> (rsp_bytes_used == '0))
      else $error("bytes used while all blocks are free");

   // A bump allocation always succeeds.
   a_reap_ok: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_from_reap) |-> (rsp_status == ST_OK))
      else $error("bump allocation reported an error");

   // A failed or rejected transaction hands out no block.
   a_err_no_block: assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_status != ST_OK)) |-> ((rsp_block_offset == '0) && !rsp_from_reap))
      else $error("error transaction carries a block");

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for superblock_block_allocator: queue-style request and
// response channels, APB-style register port, and a scoreboard that predicts every response.
// Depends on sba_pkg and the superblock_block_allocator RTL.
`timescale 1ns / 100ps

module testbench import sba_pkg::*;;

   localparam int DRAIN_CYCLES = 24;
   localparam int HOLD_CYCLES  = 250;
   localparam logic [CSR_AW-1:0] BLK_BYTES_ADDR = CSR_AW'(4 * int'(REG_BLK_BYTES));

   // Scoreboard: tracks allocator state and holds the responses still owed by the block.
   class alloc_scoreboard;
      logic [OFS_W-1:0] next_size;      // register value, taken on the next reinitialize
      logic [OFS_W-1:0] active_size;
      logic [OFS_W-1:0] bump_ofs;
      int unsigned      bump_left;
      int unsigned      free_cnt;
      int unsigned      total_cnt;
      int unsigned      depth;
      logic [OFS_W-1:0] freed_ofs [STACK_DEPTH];
      rsp_type          expected_q[$];
      int errors, n_checked, n_alloc, n_release, n_exhausted, n_misaligned, n_stack_full;

      function new();
         next_size = OFS_W'(RESET_SIZE);
         errors = 0;
         n_checked = 0;
         n_alloc = 0;
         n_release = 0;
         n_exhausted = 0;
         n_misaligned = 0;
         n_stack_full = 0;
         restart(OFS_W'(RESET_SIZE));
      endfunction

      // Recompute the geometry for a block size and clear both regions.
      function void restart(logic [OFS_W-1:0] size);
         active_size = size;
         total_cnt = 0;
         if (size != 0 && SUPER_BYTES > HEADER_BYTES) begin
            total_cnt = (SUPER_BYTES - HEADER_BYTES) / size;
         end
         if (total_cnt > CNT_MAX) begin
            total_cnt = CNT_MAX;
         end
         bump_left = total_cnt;
         free_cnt  = total_cnt;
         bump_ofs  = HEADER_OFS;
         depth     = 0;
      endfunction

      // Apply one accepted request and queue the response it must produce.
      function rsp_type note_request(op_type op, logic [OFS_W-1:0] ofs);
         rsp_type r;
         longint  used;
         r = '0;
         r.status = ST_OK;
         case (op)
            OP_ALLOC: begin
               if (bump_left > 0) begin
                  r.block_offset = bump_ofs;
                  bump_ofs = bump_ofs + active_size;
                  bump_left--;
                  r.from_reap = 1'b1;
                  if (free_cnt > 0) free_cnt--;
                  n_alloc++;
               end else if (depth > 0) begin
                  depth--;
                  r.block_offset = freed_ofs[depth];
                  if (free_cnt > 0) free_cnt--;
                  n_alloc++;
               end else begin
                  r.status = ST_NO_BLOCK;
                  n_exhausted++;
               end
            end
            OP_RELEASE: begin
               if (ofs % MIN_BLOCK != 0) begin
                  r.status = ST_MISALIGNED;
                  n_misaligned++;
               end else if (depth >= STACK_DEPTH) begin
                  r.status = ST_STACK_FULL;
                  n_stack_full++;
               end else begin
                  freed_ofs[depth] = ofs;
                  depth++;
                  if (free_cnt < CNT_MAX) free_cnt++;
                  n_release++;
               end
            end
            OP_REINIT: begin
               restart(next_size);
            end
            default: ;
         endcase

         // Used bytes are zero once more blocks are free than exist.
         used = 0;
         if (total_cnt > free_cnt) begin
            used = longint'(total_cnt - free_cnt) * active_size;
            if (used > USED_MAX) used = USED_MAX;
         end
         r.free_count = CNT_W'(free_cnt);
         r.all_free   = (free_cnt == total_cnt);
         r.bytes_used = USED_W'(used);
         expected_q.push_back(r);
         return r;
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            errors++;
         end
      endfunction

      // Compare one accepted response with the oldest outstanding prediction.
      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            $error("response transaction with no request outstanding");
            errors++;
            return;
         end
         want = expected_q.pop_front();
         n_checked++;
         compare_field("block_offset", want.block_offset, got.block_offset);
         compare_field("status", want.status, got.status);
         compare_field("from_reap", want.from_reap, got.from_reap);
         compare_field("free_count", want.free_count, got.free_count);
         compare_field("all_free", want.all_free, got.all_free);
         compare_field("bytes_used", want.bytes_used, got.bytes_used);
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              push = 1'b0;
   logic              full;
   logic [OP_W-1:0]   req_operation = '0;
   logic [OFS_W-1:0]  req_offset = '0;
   logic              empty;
   logic              pop = 1'b0;
   logic [OFS_W-1:0]  rsp_block_offset;
   logic [1:0]        rsp_status;
   logic              rsp_from_reap;
   logic [CNT_W-1:0]  rsp_free_count;
   logic              rsp_all_free;
   logic [USED_W-1:0] rsp_bytes_used;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [CSR_AW-1:0] paddr = '0;
   logic [CSR_DW-1:0] pwdata = '0;
   logic [CSR_DW-1:0] prdata;
   logic              pready;

   alloc_scoreboard sb;
   rsp_type         last_prediction;
   int              req_calm = 0;
   int              rsp_calm = 0;
   int              pop_hold_cycles = 0;
   int              settings_seen = 0;

   superblock_block_allocator DUT (.*);

   always #4 clock = ~clock;

   // Idle cycles before the next transaction; now and then a run with no idling at all.
   function automatic int draw_gap(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         calm_left = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 14);
   endfunction

   function automatic logic [OFS_W-1:0] aligned_offset();
      return OFS_W'($urandom_range(0, (1 << OFS_W) / MIN_BLOCK - 1) * MIN_BLOCK);
   endfunction

   function automatic logic [OFS_W-1:0] misaligned_offset();
      return OFS_W'($urandom_range(0, (1 << OFS_W) / MIN_BLOCK - 1) * MIN_BLOCK
                    + $urandom_range(1, MIN_BLOCK - 1));
   endfunction

   // Offer one request transaction and record its prediction once accepted.
   task automatic send_item(input op_type op, input logic [OFS_W-1:0] ofs);
      int gap;
      gap = draw_gap(req_calm);
      if (gap > 0) begin
         @(negedge clock);
         push <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      push <= 1'b1;
      req_operation <= op;
      req_offset <= ofs;
      do @(posedge clock); while (full);
      last_prediction = sb.note_request(op, ofs);
   endtask

   // Wait until every predicted response has come back, then let the block settle.
   task automatic drain_results();
      while (sb.expected_q.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write the block size while idle and read it back.
   task automatic set_blk_bytes(input logic [OFS_W-1:0] size);
      logic [CSR_DW-1:0] readback;
      @(negedge clock);
      push <= 1'b0;
      drain_results();
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= BLK_BYTES_ADDR;
      pwdata <= CSR_DW'(size);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.next_size = size;
      @(negedge clock);
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      readback = prdata;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      sb.compare_field("blk_bytes", size, readback);
      settings_seen++;
   endtask

   // Directed cases: field extremes, every operation and the corner cases.
   task automatic run_directed();
      // Reset geometry: 127 blocks of 64 bytes behind the header.
      send_item(OP_ALLOC, '1);
      send_item(OP_RELEASE, '0);             // header offset is aligned and accepted
      send_item(OP_RELEASE, '1);             // all ones, misaligned
      send_item(OP_RELEASE, OFS_W'(4));
      send_item(OP_ALLOC, '0);               // bump region still comes first
      send_item(OP_NONE, '1);
      send_item(OP_RELEASE, OFS_W'(8184));
      send_item(OP_REINIT, '0);
      send_item(OP_ALLOC, '0);
      // Largest block size leaves one block, so the allocator runs dry quickly.
      set_blk_bytes(OFS_W'(8128));
      send_item(OP_REINIT, '1);
      send_item(OP_ALLOC, '0);
      send_item(OP_ALLOC, '0);
      send_item(OP_RELEASE, OFS_W'(8184));
      send_item(OP_ALLOC, '0);
      send_item(OP_ALLOC, '0);
      send_item(OP_RELEASE, '0);
      send_item(OP_RELEASE, OFS_W'(8));      // free count now above the block count
      send_item(OP_ALLOC, '0);
      // A zero block size yields no blocks at all.
      set_blk_bytes('0);
      send_item(OP_REINIT, '0);
      send_item(OP_ALLOC, '0);
      send_item(OP_RELEASE, OFS_W'(16));
      send_item(OP_ALLOC, '0);
      send_item(OP_REINIT, '0);
   endtask

   // Fill the free stack past its depth while the response side holds off.
   task automatic run_stack_fill();
      int n;
      set_blk_bytes(OFS_W'(MIN_BLOCK));
      send_item(OP_REINIT, OFS_W'($urandom));
      pop_hold_cycles = HOLD_CYCLES;
      for (n = 0; n < STACK_DEPTH + 8; n++) begin
         send_item(OP_RELEASE, aligned_offset());
         if (n % 40 == 39) send_item(OP_RELEASE, misaligned_offset());
      end
      repeat (12) send_item(OP_ALLOC, OFS_W'($urandom));
      send_item(OP_RELEASE, aligned_offset());
      send_item(OP_REINIT, OFS_W'($urandom));
   endtask

   // Mostly allocate and release of handed-out blocks, with some noise mixed in.
   task automatic run_mixed_phase(input logic [OFS_W-1:0] size, input int count);
      logic [OFS_W-1:0] held[$];
      int pick;
      int idx;
      set_blk_bytes(size);
      send_item(OP_REINIT, OFS_W'($urandom));
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick >= 45 && pick < 80 && held.size() > 0) begin
            idx = $urandom_range(0, held.size() - 1);
            send_item(OP_RELEASE, held[idx]);
            held.delete(idx);
         end else if (pick < 80) begin
            send_item(OP_ALLOC, OFS_W'($urandom));
            if (last_prediction.status == ST_OK) held.push_back(last_prediction.block_offset);
         end else if (pick < 88) begin
            send_item(OP_RELEASE, aligned_offset());
         end else if (pick < 94) begin
            send_item(OP_RELEASE, misaligned_offset());
         end else if (pick < 97) begin
            send_item(OP_NONE, OFS_W'($urandom));
         end else begin
            send_item(OP_REINIT, OFS_W'($urandom));
            held.delete();
         end
      end
   endtask

   // Response side: random pops, with one long hold-off when asked for.
   initial begin : response_side
      int gap;
      rsp_type got;
      wait (!reset);
      forever begin
         gap = draw_gap(rsp_calm);
         if (pop_hold_cycles > 0) begin
            gap = pop_hold_cycles;
            pop_hold_cycles = 0;
         end
         if (gap > 0) begin
            @(negedge clock);
            pop <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         @(negedge clock);
         pop <= 1'b1;
         do @(posedge clock); while (empty);
         got.block_offset = rsp_block_offset;
         got.status       = status_type'(rsp_status);
         got.from_reap    = rsp_from_reap;
         got.free_count   = rsp_free_count;
         got.all_free     = rsp_all_free;
         got.bytes_used   = rsp_bytes_used;
         sb.check_response(got);
      end
   end

   // Main sequence: reset, directed cases, stack fill, then random phases.
   initial begin : stimulus
      int p;
      sb = new();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      run_directed();
      run_stack_fill();
      run_mixed_phase(OFS_W'(8128), 55);
      run_mixed_phase(OFS_W'(RESET_SIZE), 55);
      run_mixed_phase(OFS_W'(MIN_BLOCK), 55);
      for (p = 0; p < 5; p++) begin
         if (p % 2 == 0) begin
            run_mixed_phase(OFS_W'($urandom_range(2, 32) * MIN_BLOCK), 55);
         end else begin
            run_mixed_phase(OFS_W'($urandom_range(33, 1016) * MIN_BLOCK), 55);
         end
      end
      @(negedge clock);
      push <= 1'b0;
      drain_results();
      $display("Summary: %0d transactions checked under %0d block size settings.",
               sb.n_checked, settings_seen);
      $display("Summary: %0d allocations, %0d releases, %0d dry allocations,",
               sb.n_alloc, sb.n_release, sb.n_exhausted);
      $display("         %0d misaligned, %0d stack full.",
               sb.n_misaligned, sb.n_stack_full);
      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin : watchdog
      #4_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
